[hdl/stba_pkg.sv]
// shared types and constants of the space-time box average block
`default_nettype none
package stba_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int AVG_W    = 24;
    localparam int FRAME_W  = 16;
    localparam int POS_W    = 8;

    localparam logic [2:0] CFG_GRID_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_SPATIAL_RADIUS = 3'd2;
    localparam logic [2:0] CFG_TIME_BEGIN     = 3'd3;
    localparam logic [2:0] CFG_TIME_END       = 3'd4;
    localparam logic [2:0] CFG_NUM_FRAMES     = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOX,
        ST_BOX_LAST,
        ST_PLANE_WR,
        ST_CHECK,
        ST_TAP,
        ST_TAP_LAST,
        ST_DIV_SETUP,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

[hdl/space_time_box_average_missing.sv]
// space-time box average with missing data, top level
//
// input words on s_*: one grid sample (value and good flag) in raster order, frame after
// frame, or a drain tick (s_tuser high) once all samples of the sequence are in.
// output words on m_*: one averaged result per word, signed with 8 fraction bits, its
// position and frame, m_tlast on the final position of the final frame.
// config: cfg_we / cfg_index / cfg_data write one register and restart the sequence.
// timing: one word at a time. a sample word with a full window sums its box, reading
// one window sample a cycle from the row memory; a word that yields a result then
// reads the plane memory taps and runs the bit serial divider.
// results lag the input by max(time_end, 0) frames plus R rows plus R samples; the tail is
// flushed with drain words, one result each.
// reset: counters to zero, registers to their defaults; both memories need no clearing,
// only entries written in the current sequence are read.
// a stalled receiver holds the finished word in the output register; the block then
// still takes the next input word and works on it up to its own result.
`default_nettype none
module space_time_box_average_missing #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int MAX_RADIUS      = 7,
    parameter int MAX_TIME_PLANES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // sample[15:0], sample_valid[16], zero pad
    input  wire logic        s_tuser,   // action: drain tick when high
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // average[23:0], out_x[31:24], out_y[39:32],
                                        // out_frame[55:40]
    output logic             m_tuser,   // average_valid
    output logic             m_tlast,   // last_result
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    import stba_pkg::*;

    localparam int XB       = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int YB       = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
    localparam int ROW_RING = 2 * MAX_RADIUS + 1;
    localparam int SLB      = ROW_RING > 1 ? $clog2(ROW_RING) : 1;
    localparam int PRING    = MAX_TIME_PLANES > 8 ? MAX_TIME_PLANES : 8;
    localparam int PB       = $clog2(PRING);
    localparam int ROW_AW   = SLB + XB;
    localparam int PLANE_AW = PB + YB + XB;
    localparam int NB       = $clog2(MAX_TIME_PLANES + 1);
    localparam int TOT_W    = SUM_W + NB;
    localparam int NUM_W    = TOT_W + 8;
    localparam int DEN_W    = NB + 8;
    localparam int DC_W     = $clog2(NUM_W + 1);
    localparam int WH_W     = XB + YB + 1;
    localparam int CNT_W    = XB + YB + FRAME_W;

    // configuration registers
    logic        [8:0]  gw_reg, gh_reg;
    logic        [2:0]  rad_reg;
    logic signed [3:0]  tb_reg, te_reg;
    logic        [15:0] nf_reg;
    logic               restart;

    // effective settings
    logic        [XB:0]    w_eff;
    logic        [YB:0]    h_eff;
    logic        [2:0]     r_eff;
    logic        [3:0]     d_eff;
    logic        [15:0]    nt_eff;
    logic signed [6:0]     b_eff, e_eff;
    logic                  win_empty;
    logic        [WH_W-1:0]  wh_reg;
    logic        [7:0]       sq_reg;
    logic        [CNT_W-1:0] delay_reg;

    // state machine
    state_t state_reg, state_next;

    // input side position
    logic [XB-1:0]    xi_reg;
    logic [YB-1:0]    yi_reg;
    logic [SLB-1:0]   slot_reg;
    logic [15:0]      fi_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             in_done_reg;

    // output side position
    logic [XB-1:0] xo_reg;
    logic [YB-1:0] yo_reg;
    logic [15:0]   to_reg;

    // word being worked on
    logic [XB-1:0]    it_x_reg;
    logic [YB-1:0]    it_y_reg;
    logic [PB-1:0]    it_f_reg;
    logic [CNT_W-1:0] it_s_reg;
    logic             it_drain_reg;

    // box sum
    logic        [3:0]       bx_reg, by_reg;
    logic        [SLB-1:0]   bslot_reg, bslot_init;
    logic signed [SUM_W-1:0] bsum_reg;
    logic                    bgood_reg;
    logic                    rd_pend_reg;

    // time taps and divider
    logic signed [6:0]       k_reg;
    logic signed [TOT_W-1:0] tot_reg;
    logic        [NB-1:0]    n_reg;
    logic                    tp_pend_reg;
    logic        [NUM_W-1:0] num_reg;
    logic        [DEN_W:0]   rem_reg;
    logic        [DEN_W-1:0] den_reg;
    logic        [DC_W-1:0]  dcnt_reg;
    logic                    neg_reg;

    // output register
    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic        m_user_reg, m_last_reg;

    // memory ports
    logic                row_we;
    logic [ROW_AW-1:0]   row_waddr, row_raddr;
    logic [16:0]         row_rdata;
    logic                pl_we;
    logic [PLANE_AW-1:0] pl_waddr, pl_raddr;
    logic [SUM_W:0]      pl_wdata, pl_rdata;

    logic                    acc, take, box_go, give, tap_on, last_pos, tap_hit;
    logic                    out_free, in_row_end, in_frame_end;
    logic signed [17:0]      tap_f;
    logic        [2:0]       e0;
    logic        [TOT_W-1:0] tot_mag;
    logic        [DEN_W:0]   rem_sh;
    logic        [NUM_W-1:0] quot;
    logic        [AVG_W-1:0] avg;

    // ---------------------------------------------------------------- configuration
    assign restart = cfg_we && (cfg_index <= CFG_NUM_FRAMES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= 9'd256;
            gh_reg  <= 9'd256;
            rad_reg <= 3'd1;
            tb_reg  <= -4'sd1;
            te_reg  <= 4'sd1;
            nf_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:     gw_reg  <= cfg_data[8:0];
                CFG_GRID_HEIGHT:    gh_reg  <= cfg_data[8:0];
                CFG_SPATIAL_RADIUS: rad_reg <= cfg_data[2:0];
                CFG_TIME_BEGIN:     tb_reg  <= cfg_data[3:0];
                CFG_TIME_END:       te_reg  <= cfg_data[3:0];
                CFG_NUM_FRAMES:     nf_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        int bi, ei;
        bi = tb_reg;
        ei = te_reg;
        if (gw_reg == 9'd0)
            w_eff = (XB+1)'(1);
        else if (32'(gw_reg) > MAX_WIDTH)
            w_eff = (XB+1)'(MAX_WIDTH);
        else
            w_eff = (XB+1)'(gw_reg);
        if (gh_reg == 9'd0)
            h_eff = (YB+1)'(1);
        else if (32'(gh_reg) > MAX_HEIGHT)
            h_eff = (YB+1)'(MAX_HEIGHT);
        else
            h_eff = (YB+1)'(gh_reg);
        r_eff     = (32'(rad_reg) > MAX_RADIUS) ? 3'(MAX_RADIUS) : rad_reg;
        d_eff     = {r_eff, 1'b0};
        nt_eff    = (nf_reg == 16'd0) ? 16'd1 : nf_reg;
        win_empty = bi > ei;
        // a window wider than the plane budget keeps its last frames
        if (!win_empty && (ei - bi + 1 > MAX_TIME_PLANES))
            bi = ei - MAX_TIME_PLANES + 1;
        b_eff = 7'(bi);
        e_eff = 7'(ei);
        e0    = (ei > 0) ? 3'(ei) : 3'd0;
    end

    // derived products, registered; delay_reg is formed from the registered wh_reg
    always_ff @(posedge clk)
    begin
        wh_reg    <= WH_W'(w_eff) * WH_W'(h_eff);
        sq_reg    <= 8'({1'b0, r_eff, 1'b1} * {1'b0, r_eff, 1'b1});
        delay_reg <= CNT_W'(e0) * CNT_W'(wh_reg) + CNT_W'(r_eff) * CNT_W'(w_eff)
                   + CNT_W'(r_eff);
    end

    // ---------------------------------------------------------------- control
    assign acc      = s_tvalid && s_tready;
    assign take     = acc && !s_tuser && !in_done_reg;
    assign box_go   = (32'(xi_reg) >= 32'(d_eff)) && (32'(yi_reg) >= 32'(d_eff));
    assign give     = it_drain_reg || (it_s_reg >= delay_reg);
    assign tap_on   = !win_empty
                   && (32'(xo_reg) >= 32'(r_eff)) && (32'(xo_reg) + 32'(r_eff) < 32'(w_eff))
                   && (32'(yo_reg) >= 32'(r_eff)) && (32'(yo_reg) + 32'(r_eff) < 32'(h_eff));
    assign out_free = !m_valid_reg || m_tready;
    assign last_pos = (32'(xo_reg) == 32'(w_eff) - 1) && (32'(yo_reg) == 32'(h_eff) - 1)
                   && (to_reg == nt_eff - 16'd1);
    assign in_row_end   = 32'(xi_reg) == 32'(w_eff) - 1;
    assign in_frame_end = in_row_end && (32'(yi_reg) == 32'(h_eff) - 1);
    assign tap_f    = $signed({2'b00, to_reg}) + 18'(k_reg);
    assign tap_hit  = (tap_f >= 18'sd0) && (tap_f < $signed({2'b00, nt_eff}));

    always_comb
    begin
        int si;
        si = int'(slot_reg) - int'(d_eff);
        if (si < 0)
            si = si + ROW_RING;
        bslot_init = SLB'(si);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = box_go ? ST_BOX : ST_CHECK;
                else if (acc && s_tuser && in_done_reg)
                    state_next = ST_CHECK;
            end
            ST_BOX:
            begin
                if (bx_reg == d_eff && by_reg == d_eff)
                    state_next = ST_BOX_LAST;
            end
            ST_BOX_LAST:  state_next = ST_PLANE_WR;
            ST_PLANE_WR:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (!give)
                    state_next = ST_IDLE;
                else if (tap_on)
                    state_next = ST_TAP;
                else
                    state_next = ST_DIV_SETUP;
            end
            ST_TAP:
            begin
                if (k_reg == e_eff)
                    state_next = ST_TAP_LAST;
            end
            ST_TAP_LAST:  state_next = ST_DIV_SETUP;
            ST_DIV_SETUP: state_next = (n_reg == '0) ? ST_FIN : ST_DIV;
            ST_DIV:
            begin
                if (32'(dcnt_reg) == NUM_W - 1)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_tready  = state_reg == ST_IDLE;
        row_we    = take;
        row_waddr = {slot_reg, xi_reg};
        row_raddr = {bslot_reg, XB'(32'(it_x_reg) + 32'(bx_reg) - 32'(d_eff))};
        pl_we     = state_reg == ST_PLANE_WR;
        pl_waddr  = {it_f_reg, YB'(32'(it_y_reg) - 32'(r_eff)),
                     XB'(32'(it_x_reg) - 32'(r_eff))};
        pl_wdata  = {bgood_reg, bgood_reg ? bsum_reg : {SUM_W{1'b0}}};
        pl_raddr  = {tap_f[PB-1:0], yo_reg, xo_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------------------------------------------------------- position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xi_reg      <= '0;
            yi_reg      <= '0;
            slot_reg    <= '0;
            fi_reg      <= '0;
            cnt_reg     <= '0;
            in_done_reg <= 1'b0;
            xo_reg      <= '0;
            yo_reg      <= '0;
            to_reg      <= '0;
        end
        else if (restart || (state_reg == ST_FIN && out_free && last_pos))
        begin
            // new sequence
            xi_reg      <= '0;
            yi_reg      <= '0;
            slot_reg    <= '0;
            fi_reg      <= '0;
            cnt_reg     <= '0;
            in_done_reg <= 1'b0;
            xo_reg      <= '0;
            yo_reg      <= '0;
            to_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (!in_row_end)
                begin
                    xi_reg <= xi_reg + XB'(1);
                end
                else
                begin
                    xi_reg <= '0;
                    if (in_frame_end)
                    begin
                        yi_reg   <= '0;
                        slot_reg <= '0;
                        fi_reg   <= fi_reg + 16'd1;
                        if (fi_reg == nt_eff - 16'd1)
                            in_done_reg <= 1'b1;
                    end
                    else
                    begin
                        yi_reg   <= yi_reg + YB'(1);
                        slot_reg <= (32'(slot_reg) == ROW_RING - 1) ? '0 : slot_reg + SLB'(1);
                    end
                end
            end
            if (state_reg == ST_FIN && out_free)
            begin
                if (32'(xo_reg) != 32'(w_eff) - 1)
                begin
                    xo_reg <= xo_reg + XB'(1);
                end
                else
                begin
                    xo_reg <= '0;
                    if (32'(yo_reg) != 32'(h_eff) - 1)
                    begin
                        yo_reg <= yo_reg + YB'(1);
                    end
                    else
                    begin
                        yo_reg <= '0;
                        to_reg <= to_reg + 16'd1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    assign tot_mag = tot_reg[TOT_W-1] ? TOT_W'(-tot_reg) : TOT_W'(tot_reg);
    assign rem_sh  = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign quot    = neg_reg ? NUM_W'(-num_reg) : num_reg;
    assign avg     = (n_reg == '0) ? '0 : quot[AVG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            it_x_reg     <= xi_reg;
            it_y_reg     <= yi_reg;
            it_f_reg     <= fi_reg[PB-1:0];
            it_s_reg     <= cnt_reg;
            it_drain_reg <= s_tuser;
            bx_reg       <= '0;
            by_reg       <= '0;
            bslot_reg    <= bslot_init;
            bsum_reg     <= '0;
            bgood_reg    <= 1'b1;
        end
        if (state_reg == ST_BOX)
        begin
            if (bx_reg == d_eff)
            begin
                bx_reg    <= '0;
                by_reg    <= by_reg + 4'd1;
                bslot_reg <= (32'(bslot_reg) == ROW_RING - 1) ? '0 : bslot_reg + SLB'(1);
            end
            else
            begin
                bx_reg <= bx_reg + 4'd1;
            end
        end
        // window sample back from the row memory
        if (rd_pend_reg)
        begin
            if (row_rdata[16])
                bsum_reg <= bsum_reg + {{(SUM_W-SAMPLE_W){row_rdata[15]}}, row_rdata[15:0]};
            else
                bgood_reg <= 1'b0;
        end

        if (state_reg == ST_CHECK)
        begin
            k_reg   <= b_eff;
            tot_reg <= '0;
            n_reg   <= '0;
        end
        if (state_reg == ST_TAP)
        begin
            k_reg <= k_reg + 7'sd1;
        end
        // plane sum back from the plane memory
        if (tp_pend_reg && pl_rdata[SUM_W])
        begin
            tot_reg <= tot_reg + {{(TOT_W-SUM_W){pl_rdata[SUM_W-1]}}, pl_rdata[SUM_W-1:0]};
            n_reg   <= n_reg + NB'(1);
        end

        if (state_reg == ST_DIV_SETUP)
        begin
            den_reg  <= DEN_W'(n_reg) * DEN_W'(sq_reg);
            num_reg  <= {tot_mag, 8'd0};
            rem_reg  <= '0;
            dcnt_reg <= '0;
            neg_reg  <= tot_reg[TOT_W-1];
        end
        if (state_reg == ST_DIV)
        begin
            dcnt_reg <= dcnt_reg + DC_W'(1);
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end

        if (state_reg == ST_FIN && out_free)
        begin
            m_data_reg <= {to_reg, POS_W'(yo_reg), POS_W'(xo_reg), avg};
            m_user_reg <= n_reg != '0;
            m_last_reg <= last_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            tp_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= state_reg == ST_BOX;
            tp_pend_reg <= (state_reg == ST_TAP) && tap_hit;
            if (state_reg == ST_FIN && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------- memories
    // last rows of raw samples, value and good flag
    stba_ram #(
        .WIDTH (17),
        .DEPTH (1 << ROW_AW)
    ) u_row_store (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata ({s_tdata[16], s_tdata[15:0]}),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // box sums with good flag for a ring of frames
    stba_ram #(
        .WIDTH (SUM_W + 1),
        .DEPTH (1 << PLANE_AW)
    ) u_plane_store (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    // ---------------------------------------------------------------- checks
    a_box_read_from_box : assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg) == ST_BOX)
        else $error("row memory data taken outside the box sweep");

    a_tap_count : assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= MAX_TIME_PLANES)
        else $error("more frame sums than planes in the window");

    a_out_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result word loaded outside the final step");

    a_div_bound : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> 32'(dcnt_reg) < NUM_W)
        else $error("divider ran past its last bit");

endmodule
`default_nettype wire

[hdl/stba_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none
module stba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[test/tb_space_time_box_average_missing.sv]
// testbench of the space-time box average block: scoreboard class and stream drivers
`default_nettype none
module tb_space_time_box_average_missing;
    import stba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_RING    = 15;   // 2*max radius + 1 rows kept
    localparam int PLANE_RING  = 18;   // ring of recent frame planes
    localparam int ROW_LEN     = 256;
    localparam int PLANE_AREA  = 65536;
    localparam int SETTLE      = 400;  // quiet time after the last result: the slowest word, at R = 7, plus margin
    localparam int CYCLE_LIMIT = 3000000;

    // one averaged output word, as the block should give it
    typedef struct packed {
        logic [23:0] average;
        logic        average_ok;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] frame;
        logic        last;
    } avg_word_t;

    // --------------------------------------------------------------------
    // scoreboard: own copy of registers, row store and frame planes
    // --------------------------------------------------------------------
    class stba_scoreboard;
        bit [8:0]  reg_width;
        bit [8:0]  reg_height;
        bit [2:0]  reg_radius;
        bit [3:0]  reg_begin;
        bit [3:0]  reg_end;
        bit [15:0] reg_frames;

        bit [16:0] row_mem [ROW_RING*ROW_LEN];
        longint    plane_sum [longint];
        bit        plane_good [longint];
        longint    samples_in;
        longint    results_out;

        avg_word_t pending [$];
        int        errors;
        int        checked;
        int        valid_seen;

        function new();
            reg_width   = 256;
            reg_height  = 256;
            reg_radius  = 1;
            reg_begin   = 4'hF;
            reg_end     = 1;
            reg_frames  = 1;
            samples_in  = 0;
            results_out = 0;
            errors      = 0;
            checked     = 0;
            valid_seen  = 0;
            foreach (row_mem[i]) row_mem[i] = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] value);
            case (idx)
                CFG_GRID_WIDTH:     reg_width  = value[8:0];
                CFG_GRID_HEIGHT:    reg_height = value[8:0];
                CFG_SPATIAL_RADIUS: reg_radius = value[2:0];
                CFG_TIME_BEGIN:     reg_begin  = value[3:0];
                CFG_TIME_END:       reg_end    = value[3:0];
                CFG_NUM_FRAMES:     reg_frames = value;
                default:            return;
            endcase
            samples_in  = 0;
            results_out = 0;
        endfunction

        // effective settings after the clamping rules
        function void settings(output longint w, output longint h, output longint r,
                               output longint nt, output longint tb, output longint te,
                               output bit empty);
            w  = (reg_width == 0) ? 1 : ((reg_width > 256) ? 256 : reg_width);
            h  = (reg_height == 0) ? 1 : ((reg_height > 256) ? 256 : reg_height);
            r  = reg_radius;
            nt = (reg_frames == 0) ? 1 : reg_frames;
            tb = longint'($signed(reg_begin));
            te = longint'($signed(reg_end));
            empty = tb > te;
            if (!empty && te - tb + 1 > 8)
                tb = te - 7;
        endfunction

        function longint seq_total();
            longint w, h, r, nt, tb, te;
            bit     empty;
            settings(w, h, r, nt, tb, te, empty);
            return nt * w * h;
        endfunction

        function longint lag();
            longint w, h, r, nt, tb, te;
            bit     empty;
            settings(w, h, r, nt, tb, te, empty);
            return ((te > 0) ? te : 0) * w * h + r * w + r;
        endfunction

        // box sum of the window ending at this sample, stored centred
        function void store_sample(longint s, bit [15:0] value, bit good);
            longint w, h, r, nt, tb, te, f, rem, x, y, d, sum, key;
            bit     empty, all_good;
            bit [16:0] e;
            settings(w, h, r, nt, tb, te, empty);
            f   = s / (w * h);
            rem = s % (w * h);
            y   = rem / w;
            x   = rem % w;
            d   = 2 * r;
            row_mem[(y % ROW_RING) * ROW_LEN + x] = {good, value};
            if (x < d || y < d)
                return;
            sum = 0;
            all_good = 1;
            for (longint dy = 0; dy <= d; dy++)
                for (longint dx = 0; dx <= d; dx++)
                begin
                    e = row_mem[((y - d + dy) % ROW_RING) * ROW_LEN + (x - d + dx)];
                    if (!e[16])
                        all_good = 0;
                    else
                        sum += longint'($signed(e[15:0]));
                end
            key = (f % PLANE_RING) * PLANE_AREA + (y - r) * ROW_LEN + (x - r);
            plane_sum[key]  = all_good ? sum : 0;
            plane_good[key] = all_good;
        endfunction

        // temporal mean of the valid box sums for the next output position
        function void emit_average();
            longint w, h, r, nt, tb, te, l, t, rem, x, y, side, n, acc, avg, f, key;
            bit     empty, interior;
            avg_word_t res;
            settings(w, h, r, nt, tb, te, empty);
            l    = results_out;
            t    = l / (w * h);
            rem  = l % (w * h);
            y    = rem / w;
            x    = rem % w;
            side = 2 * r + 1;
            n    = 0;
            acc  = 0;
            avg  = 0;
            interior = x >= r && x + r < w && y >= r && y + r < h;
            if (interior && !empty)
                for (longint k = tb; k <= te; k++)
                begin
                    f = t + k;
                    if (f < 0 || f >= nt)
                        continue;
                    key = (f % PLANE_RING) * PLANE_AREA + y * ROW_LEN + x;
                    if (plane_good.exists(key) && plane_good[key])
                    begin
                        acc += plane_sum[key];
                        n++;
                    end
                end
            if (n > 0)
                avg = (acc * 256) / (n * side * side);
            res.average    = avg[23:0];
            res.average_ok = n > 0;
            res.col        = x[7:0];
            res.row        = y[7:0];
            res.frame      = t[15:0];
            res.last       = (l + 1 == nt * w * h);
            pending.push_back(res);
            results_out++;
            if (results_out == nt * w * h)
            begin
                samples_in  = 0;
                results_out = 0;
            end
        endfunction

        function void note_input(bit drain, bit [15:0] value, bit good);
            longint s;
            longint total;
            total = seq_total();
            if (!drain)
            begin
                if (samples_in >= total)
                    return;
                s = samples_in;
                store_sample(s, value, good);
                samples_in++;
                if (s >= lag() && results_out < total)
                    emit_average();
            end
            else if (samples_in == total && results_out < total)
                emit_average();
        endfunction

        function void check_result(avg_word_t got);
            avg_word_t exp_w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            checked++;
            if (exp_w.average_ok)
                valid_seen++;
            if (got.average !== exp_w.average)
            begin
                $display("%0t: average expected %h actual %h", $realtime, exp_w.average,
                         got.average);
                errors++;
            end
            if (got.average_ok !== exp_w.average_ok)
            begin
                $display("%0t: average_valid expected %b actual %b", $realtime,
                         exp_w.average_ok, got.average_ok);
                errors++;
            end
            if (got.col !== exp_w.col || got.row !== exp_w.row)
            begin
                $display("%0t: position expected %0d,%0d actual %0d,%0d", $realtime,
                         exp_w.col, exp_w.row, got.col, got.row);
                errors++;
            end
            if (got.frame !== exp_w.frame)
            begin
                $display("%0t: frame expected %0d actual %0d", $realtime, exp_w.frame,
                         got.frame);
                errors++;
            end
            if (got.last !== exp_w.last)
            begin
                $display("%0t: last expected %b actual %b", $realtime, exp_w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // --------------------------------------------------------------------
    // block and its signals
    // --------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // sample[15:0], sample_valid[16], zero pad
    logic        s_tuser;     // drain tick when high
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;     // average[23:0], out_x[31:24], out_y[39:32], out_frame[55:40]
    logic        m_tuser;     // average_valid
    logic        m_tlast;     // last_result
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    space_time_box_average_missing DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stba_scoreboard sb = new();

    bit     quiet_tail;     // no idling at all in the last part
    bit     hold_sink;      // request for one long receiver hold-off
    int     words_sent;
    int     phases_run;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // accepted words on both sides, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[15:0], s_tdata[16]);
            if (m_tvalid && m_tready)
                sb.check_result({m_tdata[23:0], m_tuser, m_tdata[31:24], m_tdata[39:32],
                                 m_tdata[55:40], m_tlast});
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int burst_left;
        int held;
        burst_left = 0;
        held = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                held++;
                if (held >= 3000)
                begin
                    hold_sink = 0;
                    held = 0;
                end
            end
            else if (quiet_tail)
                m_tready <= 1'b1;
            else if (burst_left > 0)
            begin
                m_tready <= 1'b0;
                burst_left--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                burst_left = $urandom_range(1, 12) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // one input word, called at a falling edge; may leave a gap after it
    task automatic push_word(bit drain, bit [15:0] value, bit good);
        s_tvalid <= 1'b1;
        s_tuser  <= drain;
        s_tdata  <= {7'd0, good, value};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        words_sent++;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // wait for every expected result, then for the block to go quiet
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
        @(negedge clk);
    endtask

    // one sequence: registers, every sample, a stray word or two, then the drain ticks
    task automatic run_sequence(int w, int h, int r, int tb, int te, int nf, int bad_pct);
        longint total;
        longint tail;
        bit [15:0] corner [6];
        corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF};
        drain_wait();
        write_cfg(CFG_GRID_WIDTH, w[15:0]);
        write_cfg(CFG_GRID_HEIGHT, h[15:0]);
        write_cfg(CFG_SPATIAL_RADIUS, r[15:0]);
        write_cfg(CFG_TIME_BEGIN, tb[15:0]);
        write_cfg(CFG_TIME_END, te[15:0]);
        write_cfg(CFG_NUM_FRAMES, nf[15:0]);
        total = sb.seq_total();
        tail  = sb.lag();
        phases_run++;
        for (longint i = 0; i < total; i++)
        begin
            // a drain before the sequence is complete yields nothing
            if ($urandom_range(0, 39) == 0)
                push_word(1'b1, 16'($urandom), 1'($urandom));
            if (i < 6 && phases_run == 1)
                push_word(1'b0, corner[i], i != 2);
            else
                push_word(1'b0, 16'($urandom), $urandom_range(0, 99) >= bad_pct);
        end
        // a sample past the end of the sequence is ignored while the tail is pending
        if (tail > 0 && $urandom_range(0, 1) == 0)
            push_word(1'b0, 16'($urandom), 1'b1);
        for (longint i = 0; i < tail; i++)
            push_word(1'b1, 16'($urandom), 1'($urandom));
        // nothing pending any more
        push_word(1'b1, 16'($urandom), 1'b1);
    endtask

    initial
    begin
        int w, h, r, tb, te, nf;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        quiet_tail  = 0;
        hold_sink   = 0;
        words_sent  = 0;
        phases_run  = 0;
        cycle_count = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extreme values, missing samples, all-ones frame count, an unused register index
        write_cfg(CFG_NUM_FRAMES, 16'hFFFF);
        write_cfg(3'd6, 16'hFFFF);                    // unused index, no effect
        run_sequence(5, 4, 1, -1, 1, 2, 10);
        // clamped temporal window, zero width, zero radius; long receiver hold-off
        hold_sink = 1;
        run_sequence(0, 3, 0, -7, 7, 3, 5);
        // begin above end: every result invalid
        run_sequence(4, 4, 1, 2, -2, 2, 0);
        // grid smaller than the box, zero frames counts as one
        run_sequence(3, 3, 2, 0, 0, 0, 0);
        // widest row, height clamped from zero
        run_sequence(511, 0, 0, 0, 0, 1, 20);
        // largest radius on a grid just big enough
        run_sequence(16, 15, 7, 0, 0, 1, 0);
        // pause the sender mid-stream until every result is out
        drain_wait();

        // random sequences with small grids
        while (words_sent < 1400)
        begin
            if (words_sent > 1150)
                quiet_tail = 1;
            w  = $urandom_range(1, 7);
            h  = $urandom_range(1, 6);
            r  = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 2);
            tb = $urandom_range(0, 14) - 7;
            te = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) - 7
                                             : tb + $urandom_range(0, 4);
            if (te > 7)
                te = 7;
            nf = $urandom_range(1, 4);
            run_sequence(w, h, r, tb, te, nf, $urandom_range(0, 3) == 0 ? 30 : 3);
        end
        drain_wait();

        $display("%0d sequences, %0d input words, %0d results checked (%0d valid averages)",
                 phases_run, words_sent, sb.checked, sb.valid_seen);
        $display("covered clamped registers, empty and wide windows, missing samples, stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
